// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds across reset.
`define ASSERT_CLKD_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fsnds_pkg.sv =====
package fsnds_pkg;

  // Directory geometry.
  localparam int MAX_ENTRIES = 512;
  localparam int POS_W       = 9;
  localparam int LIMIT_RAW_W = $clog2(MAX_ENTRIES) + 1;
  localparam int LIMIT_W     = (LIMIT_RAW_W > POS_W) ? LIMIT_RAW_W : POS_W;

  // 8.3 buffer geometry.
  localparam int NAME_LEN  = 11;
  localparam int BASE_LEN  = 8;
  localparam int FILL_W    = 4;

  // Character and marker codes.
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] MARK_END     = 8'h00;
  localparam logic [7:0] MARK_DELETED = 8'hE5;
  localparam logic [3:0] ATTR_LFN     = 4'hF;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CHAR  = 2'd1,
    OP_ENTRY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    PHASE_BASE = 2'd0,
    PHASE_FULL = 2'd1,
    PHASE_EXT  = 2'd2
  } phase_t;

  // Commands from the top level to the name buffer.
  typedef struct packed {
    logic start_name;
    logic put_char;
  } fill_cmd_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fsnds_if.sv =====
// Input channel: one command or directory entry per beat.
interface fsnds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  name_char;
  logic [63:0] entry_base;
  logic [23:0] entry_suffix;
  logic [7:0]  entry_attr;
  logic [8:0]  entry_position;
  logic        entry_final;

  modport source (
    output valid, opcode, name_char, entry_base, entry_suffix, entry_attr,
           entry_position, entry_final,
    input  ready
  );
  modport sink (
    input  valid, opcode, name_char, entry_base, entry_suffix, entry_attr,
           entry_position, entry_final,
    output ready
  );
endinterface

// Result channel: one search outcome per beat.
interface fsnds_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [8:0] found_position;

  modport source (output valid, found, found_position, input ready);
  modport sink (input valid, found, found_position, output ready);
endinterface

// ===== rtl/core/fsnds_name_fill.sv =====
module fsnds_name_fill (
  input  logic                  clk,
  input  logic                  rst,
  input  fsnds_pkg::fill_cmd_t  cmd,
  input  logic [7:0]            name_char,
  output logic [7:0]            short_name [fsnds_pkg::NAME_LEN]
);

  logic [7:0]                     name_next [fsnds_pkg::NAME_LEN];
  logic [fsnds_pkg::FILL_W-1:0]   fill_position;
  logic [fsnds_pkg::FILL_W-1:0]   fill_position_next;
  fsnds_pkg::phase_t              fill_phase;
  fsnds_pkg::phase_t              fill_phase_next;
  logic [7:0]                     up_char;

  assign up_char = fsnds_pkg::upcase(name_char);

  // Clear the 8.3 buffer on a begin command, or pack one character into it.
  always_comb begin
    name_next          = short_name;
    fill_position_next = fill_position;
    fill_phase_next    = fill_phase;
    if (cmd.start_name) begin
      for (int i = 0; i < fsnds_pkg::NAME_LEN; i++) begin
        name_next[i] = fsnds_pkg::CHAR_SPACE;
      end
      fill_position_next = '0;
      fill_phase_next    = fsnds_pkg::PHASE_BASE;
    end else if (cmd.put_char && name_char != fsnds_pkg::CHAR_NUL) begin
      unique case (fill_phase)
        fsnds_pkg::PHASE_BASE: begin
          if (name_char == fsnds_pkg::CHAR_DOT) begin
            fill_phase_next    = fsnds_pkg::PHASE_EXT;
            fill_position_next = fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN);
          end else begin
            if (fill_position < fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN)) begin
              name_next[fill_position] = up_char;
            end
            fill_position_next = fill_position + 1'b1;
            if (fill_position_next >= fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN)) begin
              fill_position_next = fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN);
              fill_phase_next    = fsnds_pkg::PHASE_FULL;
            end
          end
        end
        fsnds_pkg::PHASE_FULL: begin
          // A dot after a full base is dropped; anything else spills over.
          fill_phase_next    = fsnds_pkg::PHASE_EXT;
          fill_position_next = fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN);
          if (name_char != fsnds_pkg::CHAR_DOT) begin
            name_next[fsnds_pkg::BASE_LEN] = up_char;
            fill_position_next = fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN + 1);
          end
        end
        default: begin
          if (fill_position >= fsnds_pkg::FILL_W'(fsnds_pkg::BASE_LEN) &&
              fill_position < fsnds_pkg::FILL_W'(fsnds_pkg::NAME_LEN)) begin
            name_next[fill_position] = up_char;
            fill_position_next       = fill_position + 1'b1;
          end
        end
      endcase
    end
  end

  // Buffer and fill state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsnds_pkg::NAME_LEN; i++) begin
        short_name[i] <= fsnds_pkg::CHAR_SPACE;
      end
      fill_position <= '0;
      fill_phase    <= fsnds_pkg::PHASE_BASE;
    end else begin
      short_name    <= name_next;
      fill_position <= fill_position_next;
      fill_phase    <= fill_phase_next;
    end
  end

endmodule

// ===== rtl/core/fat_short_name_directory_search.sv =====
// FAT 8.3 short-name directory search.
// The item channel carries three kinds of beat: a begin beat clears the name
// buffer and re-arms the search, character beats build the 8.3 name, and
// directory entry beats are compared against it. The result channel carries
// one beat per search: the first matching entry, or not found when an end
// marker, an out-of-range position or the final entry is reached. Further
// entry beats are dropped until the next begin beat.
// Each item beat is captured in an input register and handled by one pass of
// compare and update logic into the result register. One item beat is taken
// every cycle while the result side is not stalled; the name buffer update is
// the only per-item loop and it is combinational.
// Synchronous reset empties both registers, fills the buffer with spaces and
// re-arms the search. When the receiver stalls, the result register holds its
// beat, one more item beat is still taken into the input register, and
// item.ready then drops until the result beat leaves.
module fat_short_name_directory_search (
  input  logic  clk,
  input  logic  rst,
  fsnds_in_if.sink    item,
  fsnds_out_if.source result
);

  logic        s1_valid;
  logic [1:0]  s1_opcode;
  logic [7:0]  s1_name_char;
  logic [63:0] s1_entry_base;
  logic [23:0] s1_entry_suffix;
  logic [7:0]  s1_entry_attr;
  logic [8:0]  s1_entry_position;
  logic        s1_entry_final;

  logic        advance;
  logic        search_finished;
  logic        search_finished_next;
  logic        emit;
  logic        emit_found;
  logic        name_match;
  logic        skipped;
  logic [7:0]  first_byte;
  logic [7:0]  short_name [fsnds_pkg::NAME_LEN];
  fsnds_pkg::fill_cmd_t fill_cmd;

  // The input register moves on whenever the result register can take a beat.
  assign advance    = !result.valid || result.ready;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready) begin
      s1_opcode         <= item.opcode;
      s1_name_char      <= item.name_char;
      s1_entry_base     <= item.entry_base;
      s1_entry_suffix   <= item.entry_suffix;
      s1_entry_attr     <= item.entry_attr;
      s1_entry_position <= item.entry_position;
      s1_entry_final    <= item.entry_final;
    end
  end

  // Name buffer commands.
  assign fill_cmd.start_name = s1_valid && advance && s1_opcode == fsnds_pkg::OP_BEGIN;
  assign fill_cmd.put_char   = s1_valid && advance && s1_opcode == fsnds_pkg::OP_CHAR;

  fsnds_name_fill u_name_fill (
    .clk        (clk),
    .rst        (rst),
    .cmd        (fill_cmd),
    .name_char  (s1_name_char),
    .short_name (short_name)
  );

  // Byte-wise compare of the entry name against the buffer.
  always_comb begin
    name_match = 1'b1;
    for (int k = 0; k < fsnds_pkg::BASE_LEN; k++) begin
      if (s1_entry_base[8*k +: 8] != short_name[k]) begin
        name_match = 1'b0;
      end
    end
    for (int k = 0; k < fsnds_pkg::NAME_LEN - fsnds_pkg::BASE_LEN; k++) begin
      if (s1_entry_suffix[8*k +: 8] != short_name[fsnds_pkg::BASE_LEN + k]) begin
        name_match = 1'b0;
      end
    end
  end

  assign first_byte = s1_entry_base[7:0];
  assign skipped    = first_byte == fsnds_pkg::MARK_DELETED ||
                      s1_entry_attr[3:0] == fsnds_pkg::ATTR_LFN ||
                      (s1_entry_attr & fsnds_pkg::ATTR_VOLUME) != 8'h00;

  // Begin re-arms the search; entries end it: end marker, range, match, last.
  always_comb begin
    emit                 = 1'b0;
    emit_found           = 1'b0;
    search_finished_next = search_finished;
    if (s1_valid && advance) begin
      unique case (s1_opcode)
        fsnds_pkg::OP_BEGIN: begin
          search_finished_next = 1'b0;
        end
        fsnds_pkg::OP_ENTRY: begin
          if (!search_finished) begin
            priority if (first_byte == fsnds_pkg::MARK_END ||
                         fsnds_pkg::LIMIT_W'(s1_entry_position) >=
                         fsnds_pkg::LIMIT_W'(fsnds_pkg::MAX_ENTRIES)) begin
              emit = 1'b1;
            end else if (!skipped && name_match) begin
              emit       = 1'b1;
              emit_found = 1'b1;
            end else if (s1_entry_final) begin
              emit = 1'b1;
            end else begin
              emit = 1'b0;
            end
            if (emit) begin
              search_finished_next = 1'b1;
            end
          end
        end
        default: begin
          search_finished_next = search_finished;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_finished <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      search_finished <= search_finished_next;
      if (advance) begin
        result.valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.found          <= emit_found;
      result.found_position <= emit_found ? s1_entry_position : '0;
    end
  end

endmodule

// ===== rtl/core/fsnds_checker.sv =====
`include "assert_macros.svh"

module fsnds_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       found,
  input logic [8:0] found_position
);

  // A stalled result beat keeps its value.
  `ASSERT_CLKD(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(found) && $stable(found_position))

  // A not-found beat always reports position zero.
  `ASSERT_CLKD(a_not_found_pos, clk, rst, result_valid && !found |-> found_position == 9'd0)

  // The item side only stalls behind a stalled result beat.
  `ASSERT_CLKD(a_ready_backpressure, clk, rst, !item_ready |-> result_valid && !result_ready)

  // Reset empties the result register.
  `ASSERT_CLKD_ANY(a_reset_empty, clk, rst |=> !result_valid)

endmodule

bind fat_short_name_directory_search fsnds_checker u_fsnds_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .found          (result.found),
  .found_position (result.found_position)
);

// ===== dv/fat_short_name_directory_search_test.sv =====
`timescale 1ns / 100ps

import fsnds_pkg::*;

// One beat on the item channel.
typedef struct {
  logic [1:0]  opcode;
  logic [7:0]  name_char;
  logic [63:0] base;
  logic [23:0] suffix;
  logic [7:0]  attr;
  logic [8:0]  position;
  logic        last_entry;
} dir_beat_t;

// One beat on the result channel.
typedef struct {
  logic       found;
  logic [8:0] position;
} lookup_outcome_t;

// Tracks the 8.3 name and search state and holds the outcomes still to come.
class name_search_scoreboard;
  logic [7:0]      name_buf [NAME_LEN];
  logic [3:0]      fill_pos;
  phase_t          phase;
  bit              done;
  lookup_outcome_t outcomes_due [$];
  int unsigned     fail_count;

  function new();
    clear_name();
    fail_count = 0;
  endfunction

  // A begin beat blanks the name and re-arms the search.
  function void clear_name();
    foreach (name_buf[k]) begin
      name_buf[k] = CHAR_SPACE;
    end
    fill_pos = '0;
    phase    = PHASE_BASE;
    done     = 1'b0;
  endfunction

  // Only ASCII a to z are folded to upper case.
  function logic [7:0] fold_case(logic [7:0] c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  // The name as an entry carries it: byte 0 in bits 7 to 0, extension on top.
  function logic [87:0] packed_name();
    logic [87:0] p;
    for (int k = 0; k < NAME_LEN; k++) begin
      p[8*k +: 8] = name_buf[k];
    end
    return p;
  endfunction

  // Applies one accepted item beat and queues the outcome it causes, if any.
  function void note_beat(dir_beat_t b);
    logic [7:0]      c;
    bit              hit;
    lookup_outcome_t o;
    case (b.opcode)
      OP_BEGIN: begin
        clear_name();
      end
      OP_CHAR: begin
        c = b.name_char;
        if (c == CHAR_NUL) begin
          // A zero character ends the string and changes nothing.
        end else if (phase == PHASE_BASE && c == CHAR_DOT) begin
          phase    = PHASE_EXT;
          fill_pos = 4'(BASE_LEN);
        end else if (phase == PHASE_BASE) begin
          name_buf[fill_pos] = fold_case(c);
          fill_pos++;
          if (fill_pos == 4'(BASE_LEN)) begin
            phase = PHASE_FULL;
          end
        end else if (phase == PHASE_FULL && c == CHAR_DOT) begin
          phase = PHASE_EXT;
        end else begin
          // Extension phase; a non-dot after a full base spills into it.
          phase = PHASE_EXT;
          if (fill_pos >= 4'(BASE_LEN) && fill_pos < 4'(NAME_LEN)) begin
            name_buf[fill_pos] = fold_case(c);
            fill_pos++;
          end
        end
      end
      OP_ENTRY: begin
        if (!done) begin
          hit = b.base[7:0] != MARK_DELETED && b.attr[3:0] != ATTR_LFN
                && !(|(b.attr & ATTR_VOLUME)) && {b.suffix, b.base} == packed_name();
          if (b.base[7:0] == MARK_END || int'(b.position) >= MAX_ENTRIES) begin
            o = '{found: 1'b0, position: 9'd0};
            outcomes_due.push_back(o);
            done = 1'b1;
          end else if (hit) begin
            o = '{found: 1'b1, position: b.position};
            outcomes_due.push_back(o);
            done = 1'b1;
          end else if (b.last_entry) begin
            o = '{found: 1'b0, position: 9'd0};
            outcomes_due.push_back(o);
            done = 1'b1;
          end
        end
      end
      default: begin
        // The spare opcode is dropped.
      end
    endcase
  endfunction

  // Compares one accepted result beat with the oldest outcome due.
  function void check_result(logic found, logic [8:0] position);
    lookup_outcome_t want;
    if (outcomes_due.size() == 0) begin
      $error("result beat with no outcome due: found %0d, found_position %0d",
             found, position);
      fail_count++;
      return;
    end
    want = outcomes_due.pop_front();
    if (found !== want.found) begin
      $error("found: expected %0d, actual %0d", want.found, found);
      fail_count++;
    end
    if (position !== want.position) begin
      $error("found_position: expected %0d, actual %0d", want.position, position);
      fail_count++;
    end
  endfunction
endclass

module fat_short_name_directory_search_test;

  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned LONG_HOLD   = 300;

  logic clk;
  logic rst;

  fsnds_in_if  item_ch ();
  fsnds_out_if result_ch ();

  name_search_scoreboard sb = new();
  bit          no_idle;
  bit          hold_request;
  int unsigned beats_sent;

  fat_short_name_directory_search u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("[fat_short_name_directory_search] ERROR");
    $finish;
  end

  // An item beat of the given opcode with random content in every other field.
  function automatic dir_beat_t blank_beat(logic [1:0] op);
    dir_beat_t b;
    b.opcode     = op;
    b.name_char  = 8'($urandom);
    b.base       = {$urandom, $urandom};
    b.suffix     = 24'($urandom);
    b.attr       = 8'($urandom);
    b.position   = 9'($urandom);
    b.last_entry = 1'($urandom);
    return b;
  endfunction

  // Filename characters, mostly letters and dots, some arbitrary bytes.
  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return CHAR_DOT;
    end
    if (r < 55) begin
      return CHAR_LOWER_A + 8'($urandom_range(0, 25));
    end
    if (r < 70) begin
      return CHAR_LOWER_A - CASE_OFFSET + 8'($urandom_range(0, 25));
    end
    if (r < 72) begin
      return CHAR_NUL;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // Offers one item beat, after a random gap unless no_idle is set, and waits for it to be taken.
  task automatic send_beat(dir_beat_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.opcode         <= b.opcode;
    item_ch.name_char      <= b.name_char;
    item_ch.entry_base     <= b.base;
    item_ch.entry_suffix   <= b.suffix;
    item_ch.entry_attr     <= b.attr;
    item_ch.entry_position <= b.position;
    item_ch.entry_final    <= b.last_entry;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    dir_beat_t b;
    b = blank_beat(OP_CHAR);
    b.name_char = c;
    send_beat(b);
  endtask

  task automatic send_entry(logic [63:0] base, logic [23:0] sfx, logic [7:0] attr,
                            logic [8:0] idx, bit last);
    dir_beat_t b;
    b = blank_beat(OP_ENTRY);
    b.base       = base;
    b.suffix     = sfx;
    b.attr       = attr;
    b.position   = idx;
    b.last_entry = last;
    send_beat(b);
  endtask

  // Directory entry built around the current name: exact, hidden, deleted, near, end marker or unrelated.
  task automatic send_random_entry(bit last);
    logic [87:0] nm;
    logic [63:0] base;
    logic [23:0] sfx;
    logic [7:0]  attr;
    logic [8:0]  idx;
    int unsigned r;
    nm   = sb.packed_name();
    base = nm[63:0];
    sfx  = nm[87:64];
    attr = 8'($urandom) & ~ATTR_VOLUME;
    r    = $urandom_range(0, 99);
    if (r < 30) begin
      // Exact name with a plain attribute.
    end else if (r < 40) begin
      if ($urandom_range(0, 1) == 0) begin
        attr = attr | ATTR_VOLUME;
      end else begin
        attr[3:0] = ATTR_LFN;
      end
    end else if (r < 48) begin
      base[7:0] = MARK_DELETED;
    end else if (r < 60) begin
      {sfx, base} = {sfx, base} ^ (88'd1 << $urandom_range(0, 87));
    end else if (r < 66) begin
      base      = {$urandom, $urandom};
      base[7:0] = MARK_END;
    end else begin
      base = {$urandom, $urandom};
      sfx  = 24'($urandom);
      attr = 8'($urandom);
    end
    r = $urandom_range(0, 9);
    idx = (r == 0) ? 9'd0 : (r == 1) ? 9'd511 : 9'($urandom);
    send_entry(base, sfx, attr, idx, last);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      sb.check_result(result_ch.found, result_ch.found_position);
    end
  end

  // Item side: reset, directed beats, a stall burst, then random searches.
  initial begin : stimulus
    logic [87:0] nm;
    int unsigned kind;
    int unsigned n;
    rst                    = 1'b1;
    item_ch.valid          = 1'b0;
    item_ch.opcode         = OP_BEGIN;
    item_ch.name_char      = '0;
    item_ch.entry_base     = '0;
    item_ch.entry_suffix   = '0;
    item_ch.entry_attr     = '0;
    item_ch.entry_position = '0;
    item_ch.entry_final    = 1'b0;
    no_idle                = 1'b0;
    hold_request           = 1'b0;
    beats_sent             = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Eight base characters around the edges of the letter fold.
    send_beat(blank_beat(OP_BEGIN));
    send_char(CHAR_LOWER_A);
    send_char(CHAR_LOWER_Z);
    send_char(CHAR_LOWER_A - 8'd1);
    send_char(CHAR_LOWER_Z + 8'd1);
    send_char(8'h40);
    send_char(8'h39);
    send_char(8'h5A);
    send_char(8'h7E);
    // A dot after a full base is dropped; one inside the extension is kept.
    send_char(CHAR_DOT);
    send_char(8'h65);
    send_char(CHAR_DOT);
    send_char(8'hFF);
    // Extension full, then a string end and the spare opcode.
    send_char(8'h71);
    send_char(CHAR_NUL);
    send_beat(blank_beat(OP_SPARE));

    // Long-file-name and volume entries are skipped even when the name fits.
    nm = sb.packed_name();
    send_entry(nm[63:0], nm[87:64], {4'h2, ATTR_LFN}, 9'd3, 1'b0);
    send_entry(nm[63:0], nm[87:64], ATTR_VOLUME, 9'd4, 1'b0);
    send_entry(nm[63:0], nm[87:64], 8'h21, 9'd511, 1'b1);
    // The search is over, so this end marker is dropped.
    send_entry({56'($urandom), MARK_END}, 24'($urandom), 8'($urandom), 9'd0, 1'b1);

    // A deleted slot never matches; then an end marker gives not found.
    send_beat(blank_beat(OP_BEGIN));
    send_char(MARK_DELETED);
    nm = sb.packed_name();
    send_entry(nm[63:0], nm[87:64], 8'h00, 9'd7, 1'b0);
    send_entry({56'($urandom), MARK_END}, 24'($urandom), 8'($urandom), 9'd8, 1'b0);

    // A last entry that does not match gives not found.
    send_beat(blank_beat(OP_BEGIN));
    send_entry({8{8'h41}}, {3{CHAR_SPACE}}, 8'h20, 9'd0, 1'b1);

    // Back-to-back searches while the result side holds off.
    no_idle      = 1'b1;
    hold_request = 1'b1;
    repeat (8) begin
      send_beat(blank_beat(OP_BEGIN));
      send_entry({56'($urandom), MARK_END}, 24'($urandom), 8'($urandom),
                 9'($urandom), 1'b0);
    end

    // Random searches, with some noise and some broken sequences.
    while (beats_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      kind    = $urandom_range(0, 9);
      if (kind < 8) begin
        send_beat(blank_beat(OP_BEGIN));
        n = $urandom_range(0, 13);
        repeat (n) send_char(pick_name_char());
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          send_random_entry((k == n - 1) ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 19) == 0));
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 8)) send_beat(blank_beat(2'($urandom)));
      end else begin
        // Characters arriving in the middle of a search.
        repeat ($urandom_range(1, 4)) send_char(pick_name_char());
        repeat ($urandom_range(1, 4)) send_random_entry($urandom_range(0, 3) == 0);
      end
    end

    // Drain the outstanding results, then watch for stray beats.
    item_ch.valid <= 1'b0;
    no_idle = 1'b1;
    while (sb.outcomes_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.fail_count == 0 && sb.outcomes_due.size() == 0) begin
      $display("[fat_short_name_directory_search] OK");
    end else begin
      $display("[fat_short_name_directory_search] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fsnds_pkg.sv
rtl/core/fsnds_if.sv
rtl/core/fsnds_name_fill.sv
rtl/core/fat_short_name_directory_search.sv
rtl/core/fsnds_checker.sv
dv/fat_short_name_directory_search_test.sv
